### sv/trimmed_mean_drop_min_max_unit_macros.svh
// Assertion macros used by the checker file of the trimmed mean unit.
`ifndef TRIMMED_MEAN_DROP_MIN_MAX_UNIT_MACROS_SVH
`define TRIMMED_MEAN_DROP_MIN_MAX_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define TMDM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define TMDM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/tmdm_pkg.sv
// Shared constants, status codes and the window summary type of the trimmed mean unit.
package tmdm_pkg;

  localparam int SAMPLE_WIDTH = 16;
  localparam int MAX_SAMPLES  = 255;
  localparam int SUM_WIDTH    = 24;
  localparam int CNT_WIDTH    = 8;
  localparam int STEP_WIDTH   = $clog2(SUM_WIDTH);
  localparam int QUEUE_DEPTH  = 2;
  localparam int QPTR_WIDTH   = $clog2(QUEUE_DEPTH);
  localparam int QCNT_WIDTH   = $clog2(QUEUE_DEPTH + 1);

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FEW  = 2'd1;
  localparam logic [1:0] ST_LONG = 2'd2;

  // Summary of one closed window, handed from front to back.
  typedef struct packed {
    logic [SUM_WIDTH-1:0]    sum;
    logic [SAMPLE_WIDTH-1:0] smallest;
    logic [SAMPLE_WIDTH-1:0] largest;
    logic [CNT_WIDTH-1:0]    count;
    logic                    overflow;
  } window_t;

endpackage

### sv/tmdm_ifs.sv
// Handshake channel interfaces for samples in and means out.
interface tmdm_sample_if;
  logic                             valid;
  logic                             ready;
  logic [tmdm_pkg::SAMPLE_WIDTH-1:0] sample;
  logic                             last;
  modport source (output valid, output sample, output last, input ready);
  modport sink   (input valid, input sample, input last, output ready);
endinterface

interface tmdm_mean_if;
  logic                             valid;
  logic                             ready;
  logic [tmdm_pkg::SAMPLE_WIDTH-1:0] average;
  logic [1:0]                       status;
  modport source (output valid, output average, output status, input ready);
  modport sink   (input valid, input average, input status, output ready);
endinterface

### sv/tmdm_front.sv
// Front end: folds each sample beat into sum, min, max and count (up to 255 per window); closes windows.
module tmdm_front (
  input  logic              clk,
  input  logic              rst,
  tmdm_sample_if.sink       samples,
  input  logic              queue_full,
  output logic              push,
  output tmdm_pkg::window_t push_data
);
  import tmdm_pkg::*;

  logic [SUM_WIDTH-1:0]    sum, sum_next;
  logic [SAMPLE_WIDTH-1:0] smallest, smallest_next;
  logic [SAMPLE_WIDTH-1:0] largest, largest_next;
  logic [CNT_WIDTH-1:0]    count, count_next;
  logic                    overflow, overflow_next;
  logic                    beat;
  logic                    room;

  assign samples.ready = !queue_full;
  assign beat          = samples.valid && samples.ready;
  assign room          = count < CNT_WIDTH'(MAX_SAMPLES);

  always_comb begin
    sum_next      = sum;
    smallest_next = smallest;
    largest_next  = largest;
    count_next    = count;
    overflow_next = overflow;
    if (room) begin
      if (count == '0) begin
        smallest_next = samples.sample;
        largest_next  = samples.sample;
      end else begin
        if (samples.sample < smallest) smallest_next = samples.sample;
        if (samples.sample > largest)  largest_next  = samples.sample;
      end
      sum_next   = sum + SUM_WIDTH'(samples.sample);
      count_next = count + 1'b1;
    end else begin
      overflow_next = 1'b1;
    end
  end

  assign push               = beat && samples.last;
  assign push_data.sum      = sum_next;
  assign push_data.smallest = smallest_next;
  assign push_data.largest  = largest_next;
  assign push_data.count    = count_next;
  assign push_data.overflow = overflow_next;

  always_ff @(posedge clk) begin
    if (rst || push) begin
      sum      <= '0;
      smallest <= '0;
      largest  <= '0;
      count    <= '0;
      overflow <= 1'b0;
    end else if (beat) begin
      sum      <= sum_next;
      smallest <= smallest_next;
      largest  <= largest_next;
      count    <= count_next;
      overflow <= overflow_next;
    end
  end

endmodule

### sv/tmdm_job_queue.sv
// Two-entry queue of closed window summaries between front and back.
module tmdm_job_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  tmdm_pkg::window_t push_data,
  output logic              full,
  output logic              job_valid,
  input  logic              pop,
  output tmdm_pkg::window_t job
);
  import tmdm_pkg::*;

  window_t                 entries [QUEUE_DEPTH];
  logic [QPTR_WIDTH-1:0]   wr_ptr;
  logic [QPTR_WIDTH-1:0]   rd_ptr;
  logic [QCNT_WIDTH-1:0]   fill;

  assign full      = fill == QCNT_WIDTH'(QUEUE_DEPTH);
  assign job_valid = fill != '0;
  assign job       = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      case ({push, pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

### sv/tmdm_back.sv
// Back end: classifies a window summary and runs the bit-serial trimmed-mean divide.
module tmdm_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              job_valid,
  input  tmdm_pkg::window_t job,
  output logic              pop,
  tmdm_mean_if.source       means
);
  import tmdm_pkg::*;

  typedef enum logic [1:0] {IDLE, DIVIDE, SHOW} state_t;

  state_t                  state;
  logic [SUM_WIDTH-1:0]    dvd;
  logic [CNT_WIDTH-1:0]    dvs;
  logic [CNT_WIDTH-1:0]    rem;
  logic [STEP_WIDTH-1:0]   step;
  logic [SAMPLE_WIDTH-1:0] average;
  logic [1:0]              status;

  logic [SUM_WIDTH-1:0]    trimmed;
  logic [CNT_WIDTH:0]      rem_shift;
  logic                    fits;
  logic [CNT_WIDTH-1:0]    rem_next;
  logic [SUM_WIDTH-1:0]    dvd_next;

  assign pop     = job_valid && (state == IDLE);
  assign trimmed = job.sum - SUM_WIDTH'(job.smallest) - SUM_WIDTH'(job.largest);

  // restoring divide, one quotient bit per cycle
  assign rem_shift = {rem, dvd[SUM_WIDTH-1]};
  assign fits      = rem_shift >= {1'b0, dvs};
  assign rem_next  = fits ? CNT_WIDTH'(rem_shift - {1'b0, dvs})
                          : rem_shift[CNT_WIDTH-1:0];
  assign dvd_next  = {dvd[SUM_WIDTH-2:0], fits};

  assign means.valid   = state == SHOW;
  assign means.average = average;
  assign means.status  = status;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
    end else begin
      unique case (state)
        IDLE: begin
          if (pop) begin
            average <= '0;
            status  <= ST_OK;
            state   <= SHOW;
            if (job.overflow) begin
              status <= ST_LONG;
            end else if (job.count <= CNT_WIDTH'(1)) begin
              status <= ST_FEW;
            end else if (job.smallest == job.largest) begin
              average <= job.smallest;
            end else if (job.count == CNT_WIDTH'(2)) begin
              status <= ST_FEW;
            end else begin
              dvd   <= trimmed;
              dvs   <= job.count - CNT_WIDTH'(2);
              rem   <= '0;
              step  <= STEP_WIDTH'(SUM_WIDTH - 1);
              state <= DIVIDE;
            end
          end
        end
        DIVIDE: begin
          dvd  <= dvd_next;
          rem  <= rem_next;
          step <= step - 1'b1;
          if (step == '0) begin
            average <= dvd_next[SAMPLE_WIDTH-1:0];
            state   <= SHOW;
          end
        end
        SHOW: begin
          if (means.ready) state <= IDLE;
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

### sv/trimmed_mean_drop_min_max_unit.sv
// Top level of the trimmed mean unit: front accumulator, window queue, divide back end.
//
// Olympic trimmed mean over windows of unsigned 16-bit converter samples.
// samples channel: one sample per beat, last marks the final sample of a window.
// means channel: one beat per window with average and status
//   (0 ok, 1 too few samples for a divisor, 2 window longer than 255 samples;
//   average is 0 whenever status is nonzero). Samples past 255 are dropped.
// Throughput: one sample beat per cycle while the queue is not full. The front
//   folds every beat into sum/min/max/count in the same cycle and hands the
//   closed window to a two-entry queue.
// Result path: the closed window passes through the queue to the back end,
//   which goes straight to SHOW when no divide is needed (all equal, too few,
//   too long) and otherwise runs the restoring divider in DIVIDE first (one
//   quotient bit per cycle over the 24-bit sum). The back end takes one window
//   at a time, so divide windows of 26 or more samples stream without a stall;
//   shorter divide windows and runs of one-sample windows fill the queue, and
//   samples.ready drops while it is full.
// Stalls: a result is held on means until taken; the back end waits, the
//   queue fills, then samples.ready goes low. Nothing is dropped.
// Reset (rst, synchronous, active high): clears the open window, the queue
//   and the back end state; samples.ready is high in the first cycle after.
module trimmed_mean_drop_min_max_unit (
  input  logic        clk,
  input  logic        rst,
  tmdm_sample_if.sink samples,
  tmdm_mean_if.source means
);
  import tmdm_pkg::*;

  logic    push;
  window_t push_data;
  logic    queue_full;
  logic    job_valid;
  logic    pop;
  window_t job;

  tmdm_front u_front (
    .clk        (clk),
    .rst        (rst),
    .samples    (samples),
    .queue_full (queue_full),
    .push       (push),
    .push_data  (push_data)
  );

  tmdm_job_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (queue_full),
    .job_valid (job_valid),
    .pop       (pop),
    .job       (job)
  );

  tmdm_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (job_valid),
    .job       (job),
    .pop       (pop),
    .means     (means)
  );

endmodule

### sv/tmdm_checker.sv
// Port-level checks on the result channel of the trimmed mean unit, bound to the top.
`include "trimmed_mean_drop_min_max_unit_macros.svh"

module tmdm_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [tmdm_pkg::SAMPLE_WIDTH-1:0] out_average,
  input logic [1:0]                      out_status
);
  import tmdm_pkg::*;

  `TMDM_ASSERT_NEXT(a_hold, out_valid && !out_ready,
    out_valid && $stable(out_average) && $stable(out_status),
    "result changed while stalled")
  `TMDM_ASSERT_NOW(a_status_code, out_valid,
    out_status == ST_OK || out_status == ST_FEW || out_status == ST_LONG,
    "undefined status code")
  `TMDM_ASSERT_NOW(a_zero_on_error, out_valid && out_status != ST_OK,
    out_average == '0, "nonzero average with error status")

endmodule

bind trimmed_mean_drop_min_max_unit tmdm_checker u_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (means.valid),
  .out_ready   (means.ready),
  .out_average (means.average),
  .out_status  (means.status)
);
